/* hdl/rpt_pkg.sv */
// Package for the rigid pose transform core: widths, register indexes and
// the rounding and saturation helpers of the datapath.
// No dependencies.
`default_nettype none

package rpt_pkg;

  // Field widths
  localparam int unsigned ROT_W     = 16;  // Q2.14 quaternion component
  localparam int unsigned POS_W     = 32;  // Q16.16 coordinate
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  // Datapath widths
  localparam int unsigned PROD_W = 32;  // Q2.14 x Q2.14 product
  localparam int unsigned M28_W  = 35;  // matrix entry, exact Q.28
  localparam int unsigned MAT_W  = 31;  // matrix entry, rounded Q.24
  localparam int unsigned PM_W   = 63;  // Q.24 entry x Q16.16 coordinate
  localparam int unsigned ACC_W  = 64;  // position sum, Q.40
  localparam int unsigned QS_W   = 35;  // Hamilton sum, Q.28

  localparam int unsigned POS_FRAC_SHIFT = 24;  // Q.40 -> Q16.16
  localparam int unsigned MAT_SHIFT      = 4;   // Q.28 -> Q.24
  localparam int unsigned QUAT_SHIFT     = 14;  // Q.28 -> Q2.14

  localparam logic signed [ROT_W-1:0]  Q14_ONE = ROT_W'(16384);
  localparam logic signed [ROT_W-1:0]  Q14_MIN = ROT_W'(-16384);
  localparam logic signed [POS_W-1:0]  POS_MAX = 32'sh7fff_ffff;
  localparam logic signed [POS_W-1:0]  POS_MIN = 32'sh8000_0000;
  localparam logic signed [M28_W-1:0]  ONE_Q28 = M28_W'(1) <<< 28;
  localparam logic signed [ACC_W-1:0]  POS_RND = ACC_W'(1) <<< (POS_FRAC_SHIFT - 1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_W   = 3'd0,
    REG_ROT_X   = 3'd1,
    REG_ROT_Y   = 3'd2,
    REG_ROT_Z   = 3'd3,
    REG_SHIFT_X = 3'd4,
    REG_SHIFT_Y = 3'd5,
    REG_SHIFT_Z = 3'd6
  } cfg_reg_e;

  // Twice a quaternion product, widened to the Q.28 matrix width
  function automatic logic signed [M28_W-1:0] dbl_q28(input logic signed [PROD_W-1:0] p);
    return M28_W'(p) <<< 1;
  endfunction

  // Widen a product to the Hamilton sum width
  function automatic logic signed [QS_W-1:0] ext_qs(input logic signed [PROD_W-1:0] p);
    return QS_W'(p);
  endfunction

  // Q.28 -> Q.24, round half up
  function automatic logic signed [MAT_W-1:0] round_q24(input logic signed [M28_W-1:0] m);
    logic signed [M28_W-1:0] t;
    t = (m + (M28_W'(1) <<< (MAT_SHIFT - 1))) >>> MAT_SHIFT;
    return MAT_W'(t);
  endfunction

  // Q.28 -> Q2.14, round half up, clamp to +-1.0
  function automatic logic signed [ROT_W-1:0] sat_q14(input logic signed [QS_W-1:0] r);
    logic signed [QS_W-1:0] t;
    t = (r + (QS_W'(1) <<< (QUAT_SHIFT - 1))) >>> QUAT_SHIFT;
    if (t > QS_W'(Q14_ONE)) begin
      return Q14_ONE;
    end else if (t < QS_W'(Q14_MIN)) begin
      return Q14_MIN;
    end
    return ROT_W'(t);
  endfunction

  // Rounded Q.40 sum -> Q16.16, clamp to the 32-bit range
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] t;
    t = a >>> POS_FRAC_SHIFT;
    if (t > ACC_W'(POS_MAX)) begin
      return POS_MAX;
    end else if (t < ACC_W'(POS_MIN)) begin
      return POS_MIN;
    end
    return POS_W'(t);
  endfunction

endpackage

`default_nettype wire

/* hdl/rigid_pose_transform_core.sv */
// Rigid pose transform core: one pose beat accepted per cycle, result
// strobed on done_o from the stage 5 output register (no stall path).
// Throughput is one beat per cycle; busy stays low.
// Depth is set by the mat x position multiply and the 64-bit sum/saturate.
// Reset clears the stage valid bits and loads the identity transform.
// Depends on rpt_pkg.
`default_nettype none

module rigid_pose_transform_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // pose input
  input  logic                                start,
  output logic                                busy,
  input  logic signed [rpt_pkg::POS_W-1:0]    pos_x_i,
  input  logic signed [rpt_pkg::POS_W-1:0]    pos_y_i,
  input  logic signed [rpt_pkg::POS_W-1:0]    pos_z_i,
  input  logic signed [rpt_pkg::ROT_W-1:0]    quat_w_i,
  input  logic signed [rpt_pkg::ROT_W-1:0]    quat_x_i,
  input  logic signed [rpt_pkg::ROT_W-1:0]    quat_y_i,
  input  logic signed [rpt_pkg::ROT_W-1:0]    quat_z_i,
  // result
  output logic                                done_o,
  output logic signed [rpt_pkg::POS_W-1:0]    out_x_o,
  output logic signed [rpt_pkg::POS_W-1:0]    out_y_o,
  output logic signed [rpt_pkg::POS_W-1:0]    out_z_o,
  output logic signed [rpt_pkg::ROT_W-1:0]    out_qw_o,
  output logic signed [rpt_pkg::ROT_W-1:0]    out_qx_o,
  output logic signed [rpt_pkg::ROT_W-1:0]    out_qy_o,
  output logic signed [rpt_pkg::ROT_W-1:0]    out_qz_o,
  // configuration write
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rpt_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [rpt_pkg::CFG_DAT_W-1:0]       cfg_data_i
);

  import rpt_pkg::*;

  // Configuration
  logic signed [ROT_W-1:0] rot_q   [4];  // w, x, y, z
  logic signed [POS_W-1:0] shift_q [3];

  // Input views
  logic signed [ROT_W-1:0] quat_in [4];
  logic signed [POS_W-1:0] pos_in  [3];
  logic                    in_acc;

  // Stage 1: products
  logic                     v1_q;
  logic signed [PROD_W-1:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, xw_q, yw_q, zw_q;
  logic signed [PROD_W-1:0] hp_q [4][4];
  logic signed [POS_W-1:0]  pos1_q [3];

  // Stage 2: matrix and Hamilton sums
  logic                     v2_q;
  logic signed [M28_W-1:0]  m28_d [3][3];
  logic signed [MAT_W-1:0]  mat_q [3][3];
  logic signed [QS_W-1:0]   qs_d  [4];
  logic signed [QS_W-1:0]   qs_q  [4];
  logic signed [POS_W-1:0]  pos2_q [3];

  // Stage 3: matrix x position, quaternion rounded
  logic                     v3_q;
  logic signed [PM_W-1:0]   pm_q [3][3];
  logic signed [ROT_W-1:0]  q3_q [4];

  // Stage 4: position sums
  logic                     v4_q;
  logic signed [ACC_W-1:0]  acc4_q [3];
  logic signed [ROT_W-1:0]  q4_q [4];

  // Stage 5: output register
  logic                     v5_q;
  logic signed [POS_W-1:0]  pos5_q [3];
  logic signed [ROT_W-1:0]  q5_q [4];

  // Handshakes: the pipeline never stalls
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign in_acc      = start & ~busy;

  assign quat_in[0] = quat_w_i;
  assign quat_in[1] = quat_x_i;
  assign quat_in[2] = quat_y_i;
  assign quat_in[3] = quat_z_i;
  assign pos_in[0]  = pos_x_i;
  assign pos_in[1]  = pos_y_i;
  assign pos_in[2]  = pos_z_i;

  // Configuration registers, unknown index ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0]   <= Q14_ONE;
      rot_q[1]   <= '0;
      rot_q[2]   <= '0;
      rot_q[3]   <= '0;
      shift_q[0] <= '0;
      shift_q[1] <= '0;
      shift_q[2] <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ROT_W:   rot_q[0]   <= cfg_data_i[ROT_W-1:0];
        REG_ROT_X:   rot_q[1]   <= cfg_data_i[ROT_W-1:0];
        REG_ROT_Y:   rot_q[2]   <= cfg_data_i[ROT_W-1:0];
        REG_ROT_Z:   rot_q[3]   <= cfg_data_i[ROT_W-1:0];
        REG_SHIFT_X: shift_q[0] <= cfg_data_i[POS_W-1:0];
        REG_SHIFT_Y: shift_q[1] <= cfg_data_i[POS_W-1:0];
        REG_SHIFT_Z: shift_q[2] <= cfg_data_i[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= in_acc;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Stage 1: quaternion pair products and Hamilton partial products
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      xx_q <= rot_q[1] * rot_q[1];
      yy_q <= rot_q[2] * rot_q[2];
      zz_q <= rot_q[3] * rot_q[3];
      xy_q <= rot_q[1] * rot_q[2];
      xz_q <= rot_q[1] * rot_q[3];
      yz_q <= rot_q[2] * rot_q[3];
      xw_q <= rot_q[1] * rot_q[0];
      yw_q <= rot_q[2] * rot_q[0];
      zw_q <= rot_q[3] * rot_q[0];
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          hp_q[i][j] <= rot_q[i] * quat_in[j];
        end
      end
      for (int k = 0; k < 3; k++) begin
        pos1_q[k] <= pos_in[k];
      end
    end
  end

  // Stage 2: rotation matrix in Q.28, Hamilton product sums
  always_comb begin
    m28_d[0][0] = ONE_Q28 - dbl_q28(yy_q) - dbl_q28(zz_q);
    m28_d[0][1] = dbl_q28(xy_q) - dbl_q28(zw_q);
    m28_d[0][2] = dbl_q28(xz_q) + dbl_q28(yw_q);
    m28_d[1][0] = dbl_q28(xy_q) + dbl_q28(zw_q);
    m28_d[1][1] = ONE_Q28 - dbl_q28(xx_q) - dbl_q28(zz_q);
    m28_d[1][2] = dbl_q28(yz_q) - dbl_q28(xw_q);
    m28_d[2][0] = dbl_q28(xz_q) - dbl_q28(yw_q);
    m28_d[2][1] = dbl_q28(yz_q) + dbl_q28(xw_q);
    m28_d[2][2] = ONE_Q28 - dbl_q28(xx_q) - dbl_q28(yy_q);

    qs_d[0] = ext_qs(hp_q[0][0]) - ext_qs(hp_q[1][1])
            - ext_qs(hp_q[2][2]) - ext_qs(hp_q[3][3]);
    qs_d[1] = ext_qs(hp_q[1][0]) + ext_qs(hp_q[0][1])
            - ext_qs(hp_q[3][2]) + ext_qs(hp_q[2][3]);
    qs_d[2] = ext_qs(hp_q[2][0]) + ext_qs(hp_q[3][1])
            + ext_qs(hp_q[0][2]) - ext_qs(hp_q[1][3]);
    qs_d[3] = ext_qs(hp_q[3][0]) - ext_qs(hp_q[2][1])
            + ext_qs(hp_q[1][2]) + ext_qs(hp_q[0][3]);
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          mat_q[i][j] <= round_q24(m28_d[i][j]);
        end
        pos2_q[i] <= pos1_q[i];
      end
      qs_q <= qs_d;
    end
  end

  // Stage 3: matrix times position, orientation rounded and clamped
  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pm_q[i][j] <= mat_q[i][j] * pos2_q[j];
        end
      end
      for (int k = 0; k < 4; k++) begin
        q3_q[k] <= sat_q14(qs_q[k]);
      end
    end
  end

  // Stage 4: row sums plus translation and rounding offset
  always_ff @(posedge clk_i) begin
    if (v3_q) begin
      for (int i = 0; i < 3; i++) begin
        acc4_q[i] <= (ACC_W'(shift_q[i]) <<< POS_FRAC_SHIFT) + ACC_W'(pm_q[i][0])
                   + ACC_W'(pm_q[i][1]) + ACC_W'(pm_q[i][2]) + POS_RND;
      end
      q4_q <= q3_q;
    end
  end

  // Stage 5: scale to Q16.16 and clamp
  always_ff @(posedge clk_i) begin
    if (v4_q) begin
      for (int i = 0; i < 3; i++) begin
        pos5_q[i] <= sat_pos(acc4_q[i]);
      end
      q5_q <= q4_q;
    end
  end

  assign done_o   = v5_q;
  assign out_x_o  = pos5_q[0];
  assign out_y_o  = pos5_q[1];
  assign out_z_o  = pos5_q[2];
  assign out_qw_o = q5_q[0];
  assign out_qx_o = q5_q[1];
  assign out_qy_o = q5_q[2];
  assign out_qz_o = q5_q[3];

  // Every accepted beat comes out on done_o, and every result has a matching accepted beat
  a_lat_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##5 done_o)
    else $error("accepted beat produced no result");

  a_lat_back : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 5))
    else $error("result without a matching accepted beat");

  // Orientation results stay within +-1.0
  a_quat_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (out_qw_o <= Q14_ONE && out_qw_o >= Q14_MIN &&
                out_qx_o <= Q14_ONE && out_qx_o >= Q14_MIN &&
                out_qy_o <= Q14_ONE && out_qy_o >= Q14_MIN &&
                out_qz_o <= Q14_ONE && out_qz_o >= Q14_MIN))
    else $error("orientation result out of range");

endmodule

`default_nettype wire

/* tb/rigid_pose_transform_core_test.sv */
// Self-checking testbench for rigid_pose_transform_core: drives pose beats and
// register writes, predicts each transformed pose and checks every strobed result.
// Depends on rpt_pkg and rigid_pose_transform_core.
`timescale 1ns / 1ps

module rigid_pose_transform_core_test;
  import rpt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;  // no register behind it
  localparam longint UNIT_Q28   = longint'(1) <<< 28;
  localparam longint POS_HI     = 64'sd2147483647;
  localparam longint POS_LO     = -64'sd2147483648;
  localparam longint QUAT_LIM   = 64'sd16384;
  localparam int     TAIL_CYCLES  = 20;
  localparam int     RAND_PHASES  = 10;
  localparam int     PHASE_POSES  = 155;

  typedef enum {JOB_POSE, JOB_CFG, JOB_DRAIN} job_kind_e;

  typedef struct {
    logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
    logic signed [ROT_W-1:0] quat_w, quat_x, quat_y, quat_z;
  } pose_t;

  typedef struct {
    logic signed [POS_W-1:0] out_x, out_y, out_z;
    logic signed [ROT_W-1:0] out_qw, out_qx, out_qy, out_qz;
  } res_t;

  typedef struct {
    job_kind_e               kind;
    pose_t                   pose;
    logic [CFG_IDX_W-1:0]    index;
    logic [CFG_DAT_W-1:0]    data;
    int                      gap;
  } job_t;

  // DUT inputs, known from time zero
  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    start       = 1'b0;
  logic signed [POS_W-1:0] pos_x_i     = '0;
  logic signed [POS_W-1:0] pos_y_i     = '0;
  logic signed [POS_W-1:0] pos_z_i     = '0;
  logic signed [ROT_W-1:0] quat_w_i    = '0;
  logic signed [ROT_W-1:0] quat_x_i    = '0;
  logic signed [ROT_W-1:0] quat_y_i    = '0;
  logic signed [ROT_W-1:0] quat_z_i    = '0;
  logic                    cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_DAT_W-1:0]    cfg_data_i  = '0;

  // DUT outputs
  logic                    busy, done_o, cfg_ready_o;
  logic signed [POS_W-1:0] out_x_o, out_y_o, out_z_o;
  logic signed [ROT_W-1:0] out_qw_o, out_qx_o, out_qy_o, out_qz_o;

  // Shadow transform, reset value is identity with no shift
  longint xform_rot [4]   = '{64'sd16384, 64'sd0, 64'sd0, 64'sd0};
  longint xform_shift [3] = '{64'sd0, 64'sd0, 64'sd0};

  job_t   pending_jobs[$];
  res_t   predicted_poses[$];
  int     fail_count      = 0;
  int     poses_sent      = 0;
  int     results_checked = 0;
  int     cfg_writes      = 0;

  // driver bookkeeping
  int     gap_left   = 0;
  bit     head_armed = 1'b0;
  int     in_flight  = 0;

  rigid_pose_transform_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .pos_z_i     (pos_z_i),
    .quat_w_i    (quat_w_i),
    .quat_x_i    (quat_x_i),
    .quat_y_i    (quat_y_i),
    .quat_z_i    (quat_z_i),
    .done_o      (done_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .out_qw_o    (out_qw_o),
    .out_qx_o    (out_qx_o),
    .out_qy_o    (out_qy_o),
    .out_qz_o    (out_qz_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // floor((v + half) / 2^s)
  function automatic longint round_down_shift(input longint v, input int unsigned s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Rotate and shift the position, compose the orientation with the transform
  function automatic res_t transform_pose(input pose_t p);
    longint w, x, y, z, acc;
    longint m [3][3];
    longint pv [3];
    longint qv [4];
    longint hp [4];
    longint po [3];
    res_t   r;
    w = xform_rot[0];
    x = xform_rot[1];
    y = xform_rot[2];
    z = xform_rot[3];
    // rotation matrix, exact Q.28, no normalization
    m[0][0] = UNIT_Q28 - 2*y*y - 2*z*z;
    m[0][1] = 2*x*y - 2*z*w;
    m[0][2] = 2*x*z + 2*y*w;
    m[1][0] = 2*x*y + 2*z*w;
    m[1][1] = UNIT_Q28 - 2*x*x - 2*z*z;
    m[1][2] = 2*y*z - 2*x*w;
    m[2][0] = 2*x*z - 2*y*w;
    m[2][1] = 2*y*z + 2*x*w;
    m[2][2] = UNIT_Q28 - 2*x*x - 2*y*y;
    pv[0] = p.pos_x;
    pv[1] = p.pos_y;
    pv[2] = p.pos_z;
    qv[0] = p.quat_w;
    qv[1] = p.quat_x;
    qv[2] = p.quat_y;
    qv[3] = p.quat_z;
    // position: Q.24 entries times Q16.16 coordinates, summed in Q.40
    for (int i = 0; i < 3; i++) begin
      acc = xform_shift[i] * (longint'(1) <<< 24);
      for (int j = 0; j < 3; j++) begin
        acc += round_down_shift(m[i][j], 4) * pv[j];
      end
      po[i] = clamp_to(round_down_shift(acc, 24), POS_LO, POS_HI);
    end
    // Hamilton product transform * pose
    hp[0] = w*qv[0] - x*qv[1] - y*qv[2] - z*qv[3];
    hp[1] = x*qv[0] + w*qv[1] - z*qv[2] + y*qv[3];
    hp[2] = y*qv[0] + z*qv[1] + w*qv[2] - x*qv[3];
    hp[3] = z*qv[0] - y*qv[1] + x*qv[2] + w*qv[3];
    for (int i = 0; i < 4; i++) begin
      hp[i] = clamp_to(round_down_shift(hp[i], 14), -QUAT_LIM, QUAT_LIM);
    end
    r.out_x  = POS_W'(po[0]);
    r.out_y  = POS_W'(po[1]);
    r.out_z  = POS_W'(po[2]);
    r.out_qw = ROT_W'(hp[0]);
    r.out_qx = ROT_W'(hp[1]);
    r.out_qy = ROT_W'(hp[2]);
    r.out_qz = ROT_W'(hp[3]);
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  function automatic pose_t make_pose(input logic signed [POS_W-1:0] px, py, pz,
                                      input logic signed [ROT_W-1:0] qw, qx, qy, qz);
    pose_t p;
    p = '{px, py, pz, qw, qx, qy, qz};
    return p;
  endfunction

  // Mostly short gaps, now and then a long one; none at all in burst phases
  function automatic int pick_gap(input bit burst);
    int roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Random unit quaternion, packed {w, x, y, z} in Q2.14
  function automatic logic [63:0] rand_unit_quat();
    real         c [4];
    real         n;
    logic [63:0] q;
    do begin
      n = 0.0;
      for (int k = 0; k < 4; k++) begin
        c[k] = real'(int'($urandom_range(0, 20000)) - 10000) / 10000.0;
        n += c[k] * c[k];
      end
    end while (n < 0.01);
    n = $sqrt(n);
    for (int k = 0; k < 4; k++) begin
      q[63 - 16*k -: 16] = 16'($rtoi(c[k] / n * 16384.0));
    end
    return q;
  endfunction

  function automatic logic [31:0] moderate_coord();
    return 32'(int'($urandom_range(0, 1 << 27)) - (1 << 26));
  endfunction

  // Well-formed pose most of the time, raw bit noise otherwise
  function automatic pose_t rand_pose();
    logic [63:0] q;
    if ($urandom_range(0, 99) < 80) begin
      q = rand_unit_quat();
      return make_pose(moderate_coord(), moderate_coord(), moderate_coord(),
                       q[63:48], q[47:32], q[31:16], q[15:0]);
    end
    return make_pose($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom));
  endfunction

  task automatic queue_pose(input pose_t p, input int gap);
    job_t j;
    j = '{JOB_POSE, p, '0, '0, gap};
    pending_jobs.push_back(j);
  endtask

  task automatic queue_write(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DAT_W-1:0] data);
    job_t j;
    j = '{JOB_CFG, make_pose(0, 0, 0, 0, 0, 0, 0), index, data, $urandom_range(0, 3)};
    pending_jobs.push_back(j);
  endtask

  task automatic queue_drain();
    job_t j;
    j = '{JOB_DRAIN, make_pose(0, 0, 0, 0, 0, 0, 0), '0, '0, $urandom_range(0, 5)};
    pending_jobs.push_back(j);
  endtask

  // Full transform update; junk in the unused upper bits of the rotation words
  task automatic queue_xform(input logic signed [ROT_W-1:0] w, x, y, z,
                             input logic signed [POS_W-1:0] sx, sy, sz);
    queue_write(REG_ROT_W,   {16'($urandom), w});
    queue_write(REG_ROT_X,   {16'($urandom), x});
    queue_write(REG_ROT_Y,   {16'($urandom), y});
    queue_write(REG_ROT_Z,   {16'($urandom), z});
    queue_write(REG_SHIFT_X, sx);
    queue_write(REG_SHIFT_Y, sy);
    queue_write(REG_SHIFT_Z, sz);
  endtask

  function automatic logic [15:0] extreme_rot();
    case ($urandom_range(0, 4))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'h8000;
      3: return 16'h7fff;
      default: return 16'h0000;
    endcase
  endfunction

  function automatic logic [31:0] extreme_shift();
    case ($urandom_range(0, 3))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      default: return 32'h0000_0000;
    endcase
  endfunction

  task automatic queue_random_xform(input int mode);
    logic [63:0] q;
    case (mode)
      0: begin
        q = rand_unit_quat();
        queue_xform(q[63:48], q[47:32], q[31:16], q[15:0],
                    moderate_coord(), moderate_coord(), moderate_coord());
      end
      1: queue_xform(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     $urandom, $urandom, $urandom);
      2: queue_xform(extreme_rot(), extreme_rot(), extreme_rot(), extreme_rot(),
                     extreme_shift(), extreme_shift(), extreme_shift());
      default: begin
        q = rand_unit_quat();
        queue_xform(q[63:48], q[47:32], q[31:16], q[15:0], $urandom, $urandom, $urandom);
      end
    endcase
  endtask

  // Driver: one pending job at a time; transform writes wait for an empty pipeline
  always @(posedge clk_i) begin
    if (rst_ni) begin : drive
      bit offer_pose, offer_cfg;
      offer_pose = 1'b0;
      offer_cfg  = 1'b0;
      if (start && !busy) begin
        void'(pending_jobs.pop_front());
        head_armed = 1'b0;
        in_flight++;
      end else if (start) begin
        offer_pose = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        void'(pending_jobs.pop_front());
        head_armed = 1'b0;
      end else if (cfg_valid_i) begin
        offer_cfg = 1'b1;
      end
      if (done_o) in_flight--;

      if (!offer_pose && !offer_cfg && pending_jobs.size() != 0) begin
        if (!head_armed) begin
          gap_left   = pending_jobs[0].gap;
          head_armed = 1'b1;
        end
        if (pending_jobs[0].kind == JOB_POSE) begin
          if (gap_left == 0) offer_pose = 1'b1;
          else gap_left--;
        end else if (in_flight != 0) begin
          gap_left = pending_jobs[0].gap;  // quiet time counts from the last result
        end else if (gap_left != 0) begin
          gap_left--;
        end else if (pending_jobs[0].kind == JOB_CFG) begin
          offer_cfg = 1'b1;
        end else begin
          void'(pending_jobs.pop_front());
          head_armed = 1'b0;
        end
      end

      start       <= offer_pose;
      cfg_valid_i <= offer_cfg;
      if (offer_pose) begin
        pos_x_i  <= pending_jobs[0].pose.pos_x;
        pos_y_i  <= pending_jobs[0].pose.pos_y;
        pos_z_i  <= pending_jobs[0].pose.pos_z;
        quat_w_i <= pending_jobs[0].pose.quat_w;
        quat_x_i <= pending_jobs[0].pose.quat_x;
        quat_y_i <= pending_jobs[0].pose.quat_y;
        quat_z_i <= pending_jobs[0].pose.quat_z;
      end
      if (offer_cfg) begin
        cfg_index_i <= pending_jobs[0].index;
        cfg_data_i  <= pending_jobs[0].data;
      end
    end
  end

  // Monitor: check strobed results, track transform writes, predict accepted poses
  always @(posedge clk_i) begin
    if (rst_ni) begin : observe
      res_t want;
      if (done_o) begin
        if (predicted_poses.size() == 0) begin
          $error("result strobed with no pose outstanding");
          fail_count++;
        end else begin
          want = predicted_poses.pop_front();
          check_field("out_x",  want.out_x,  out_x_o);
          check_field("out_y",  want.out_y,  out_y_o);
          check_field("out_z",  want.out_z,  out_z_o);
          check_field("out_qw", want.out_qw, out_qw_o);
          check_field("out_qx", want.out_qx, out_qx_o);
          check_field("out_qy", want.out_qy, out_qy_o);
          check_field("out_qz", want.out_qz, out_qz_o);
          results_checked++;
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_writes++;
        case (cfg_index_i)
          REG_ROT_W:   xform_rot[0]   = longint'($signed(cfg_data_i[ROT_W-1:0]));
          REG_ROT_X:   xform_rot[1]   = longint'($signed(cfg_data_i[ROT_W-1:0]));
          REG_ROT_Y:   xform_rot[2]   = longint'($signed(cfg_data_i[ROT_W-1:0]));
          REG_ROT_Z:   xform_rot[3]   = longint'($signed(cfg_data_i[ROT_W-1:0]));
          REG_SHIFT_X: xform_shift[0] = longint'($signed(cfg_data_i));
          REG_SHIFT_Y: xform_shift[1] = longint'($signed(cfg_data_i));
          REG_SHIFT_Z: xform_shift[2] = longint'($signed(cfg_data_i));
          default: ;  // unmapped index, write dropped
        endcase
      end
      if (start && !busy) begin
        predicted_poses.push_back(transform_pose(make_pose(pos_x_i, pos_y_i, pos_z_i,
            quat_w_i, quat_x_i, quat_y_i, quat_z_i)));
        poses_sent++;
      end
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    int drain_at;
    bit burst;

    // directed: identity transform from reset
    queue_pose(make_pose(0, 0, 0, 0, 0, 0, 0), 0);
    queue_pose(make_pose(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                         16'sd16384, 0, 0, 0), 0);
    queue_pose(make_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         -16'sd16384, 0, 0, 0), 1);
    queue_pose(make_pose(1, -1, 0, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff), 0);
    queue_pose(make_pose(32'h5555_5555, 32'h5555_5555, 32'h5555_5555,
                         16'h5555, 16'h5555, 16'h5555, 16'h5555), 0);
    queue_pose(make_pose(32'haaaa_aaaa, 32'haaaa_aaaa, 32'haaaa_aaaa,
                         16'haaaa, 16'haaaa, 16'haaaa, 16'haaaa), 2);

    // out-of-range rotation words and extreme shifts, to exercise saturation
    queue_xform(16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000);
    queue_pose(make_pose(32'h7fff_ffff, 32'h8000_0000, 1,
                         16'sd16384, 16'sd16384, -16'sd16384, 0), 0);
    queue_pose(make_pose(0, 0, 0, 0, 0, 0, 0), 0);
    queue_pose(make_pose(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                         16'h8000, 16'h8000, 16'h8000, 16'h8000), 0);
    // write to the unmapped index must leave the transform alone
    queue_write(REG_UNUSED, 32'hffff_ffff);
    queue_pose(make_pose(0, 0, 0, 0, 0, 0, 0), 0);

    // quarter turn about z, shifts of +1.0, -1.0 and the largest value
    queue_xform(16'sd11585, 0, 0, 16'sd11585, 32'h0001_0000, 32'hffff_0000, 32'h7fff_ffff);
    queue_pose(make_pose(32'h0001_0000, 0, 0, 16'sd11585, 0, 0, 16'sd11585), 0);
    queue_pose(make_pose(0, 32'h0001_0000, 0, 16'sd16384, 0, 0, 0), 0);
    queue_pose(make_pose(1, 1, 1, 0, 16'sd8192, 16'sd8192, 0), 0);

    // non-unit rotation, used as written
    queue_xform(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_pose(make_pose(32'h0010_0000, 32'hfff0_0000, 32'h0000_8000,
                         16'sd16384, 0, 0, 0), 0);
    queue_pose(make_pose(-1, -1, -1, -16'sd1, 16'sd1, -16'sd1, 16'sd1), 0);

    // negated identity
    queue_xform(-16'sd16384, 0, 0, 0, 0, 0, 0);
    queue_pose(make_pose(32'h1234_5678, 32'hedcb_a988, 32'h0000_0001,
                         16'sd16384, 16'sd100, -16'sd100, 16'sd7), 0);
    queue_pose(make_pose(7, 8, 9, 16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192), 0);

    // random phases: fresh transform each time, one forced drain at a random point
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      queue_random_xform(ph % 4);
      if (ph == 0) queue_write(REG_UNUSED, $urandom);
      burst    = (ph % 3 == 2);
      drain_at = $urandom_range(20, PHASE_POSES - 20);
      for (int k = 0; k < PHASE_POSES; k++) begin
        if (k == drain_at) queue_drain();
        queue_pose(rand_pose(), pick_gap(burst));
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i); while (pending_jobs.size() != 0 || predicted_poses.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (predicted_poses.size() != 0) begin
      $error("%0d results never strobed", predicted_poses.size());
      fail_count++;
    end
    $display("Covered %0d poses under %0d register writes, including extreme and unmapped ones.",
             poses_sent, cfg_writes);
    $display("%0d results checked field by field, %0d mismatches.", results_checked, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* files.f */
hdl/rpt_pkg.sv
hdl/rigid_pose_transform_core.sv
tb/rigid_pose_transform_core_test.sv
